@@ src/multichannel_biquad_shelf_filter_assert.svh @@
// assertion macros for the checker file of the shelf filter
`ifndef MULTICHANNEL_BIQUAD_SHELF_FILTER_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_SHELF_FILTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MBSF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MBSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mbsf_pkg.sv @@
// shared types, constants and saturation helpers of the shelf filter
package mbsf_pkg;

    localparam int MAX_CHANNELS = 2;
    localparam int CH_IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 27;
    localparam int DELAY_W   = 48;
    localparam int FRAC_W    = 23;
    localparam int MUL_ACC_W = COEF_W + 1;
    localparam int PROD_W    = MUL_ACC_W + SAMPLE_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MUL_CNT_W = $clog2(SAMPLE_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    // rounding bias and saturation limits at accumulator width
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] Y_HI = (SUM_W'(1) << (SAMPLE_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] Y_LO = ~Y_HI;
    localparam logic signed [SUM_W-1:0] D_HI = (SUM_W'(1) << (DELAY_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] D_LO = ~D_HI;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0       = 3'd0,
        REG_COEF_B1       = 3'd1,
        REG_COEF_B2       = 3'd2,
        REG_COEF_A1       = 3'd3,
        REG_COEF_A2       = 3'd4,
        REG_EQ_IN         = 3'd5,
        REG_FILTER_ACTIVE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       channel;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       channel_out;
    } out_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_b0;
        logic signed [COEF_W-1:0] coef_b1;
        logic signed [COEF_W-1:0] coef_b2;
        logic signed [COEF_W-1:0] coef_a1;
        logic signed [COEF_W-1:0] coef_a2;
        logic                     eq_in;
        logic                     filter_active;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } core_stat_t;

    // clamp to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > Y_HI) begin
            c = Y_HI;
        end else if (v < Y_LO) begin
            c = Y_LO;
        end else begin
            c = v;
        end
        return c[SAMPLE_W-1:0];
    endfunction

    // clamp to the delay term range
    function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > D_HI) begin
            c = D_HI;
        end else if (v < D_LO) begin
            c = D_LO;
        end else begin
            c = v;
        end
        return c[DELAY_W-1:0];
    endfunction

endpackage

@@ src/mbsf_serial_mul.sv @@
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
module mbsf_serial_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [mbsf_pkg::COEF_W-1:0]    coef,
    input  logic signed [mbsf_pkg::SAMPLE_W-1:0]  mplier,
    output logic                                  done,
    output logic signed [mbsf_pkg::PROD_W-1:0]    product
);

    logic signed [mbsf_pkg::MUL_ACC_W-1:0] acc_reg, acc_next;
    logic [mbsf_pkg::SAMPLE_W-1:0]         lo_reg, lo_next;
    logic [mbsf_pkg::SAMPLE_W-1:0]         mr_reg, mr_next;
    logic signed [mbsf_pkg::COEF_W-1:0]    md_reg, md_next;
    logic [mbsf_pkg::MUL_CNT_W-1:0]        cnt_reg, cnt_next;
    logic                                  run_reg, run_next;
    logic                                  done_reg, done_next;
    logic signed [mbsf_pkg::MUL_ACC_W:0]   pp;
    logic signed [mbsf_pkg::MUL_ACC_W:0]   sum;
    logic                                  last;

    // partial product, the sign bit of the multiplier weighs negative
    always_comb begin
        last = (cnt_reg == mbsf_pkg::MUL_CNT_W'(mbsf_pkg::SAMPLE_W - 1));
        pp   = mr_reg[0]
             ? $signed({{(mbsf_pkg::MUL_ACC_W + 1 - mbsf_pkg::COEF_W){md_reg[mbsf_pkg::COEF_W-1]}},
                        md_reg})
             : '0;
        sum  = $signed({acc_reg[mbsf_pkg::MUL_ACC_W-1], acc_reg}) + (last ? -pp : pp);
    end

    // next state: add, then shift the whole product right by one
    always_comb begin
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        mr_next   = mr_reg;
        md_next   = md_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = '0;
            lo_next  = '0;
            mr_next  = mplier;
            md_next  = coef;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            acc_next = sum[mbsf_pkg::MUL_ACC_W:1];
            lo_next  = {sum[0], lo_reg[mbsf_pkg::SAMPLE_W-1:1]};
            mr_next  = mr_reg >> 1;
            cnt_next = cnt_reg + mbsf_pkg::MUL_CNT_W'(1);
            if (last) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk) begin
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
        mr_reg  <= mr_next;
        md_reg  <= md_next;
    end

    assign done    = done_reg;
    assign product = {acc_reg, lo_reg};

endmodule

@@ src/mbsf_core.sv @@
// biquad sequencer: per-channel delay state, serial products, round and saturate
module mbsf_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mbsf_pkg::in_item_t   item,
    input  mbsf_pkg::cfg_t       cfg,
    input  logic                 res_ack,
    output mbsf_pkg::core_stat_t stat,
    output mbsf_pkg::out_item_t  result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULX,
        S_SUM,
        S_RND,
        S_MULY,
        S_UPD,
        S_DONE
    } state_t;

    state_t state_reg;

    logic signed [mbsf_pkg::SAMPLE_W-1:0] res_reg;
    logic signed [mbsf_pkg::DELAY_W-1:0]  z1_reg [mbsf_pkg::MAX_CHANNELS];
    logic signed [mbsf_pkg::DELAY_W-1:0]  z2_reg [mbsf_pkg::MAX_CHANNELS];

    logic signed [mbsf_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [mbsf_pkg::SAMPLE_W-1:0] y_reg;
    logic                                 ch_reg;
    logic                                 eq_reg;
    logic signed [mbsf_pkg::SUM_W-1:0]    acc_reg;
    logic signed [mbsf_pkg::SUM_W-1:0]    t1_reg;
    logic signed [mbsf_pkg::PROD_W-1:0]   bx2_reg;

    logic [mbsf_pkg::CH_IDX_W-1:0]        ch_idx;
    logic                                 in_range;
    logic                                 run_filter;
    logic                                 fb_phase;
    logic signed [mbsf_pkg::SAMPLE_W-1:0] y_next;
    logic signed [mbsf_pkg::SUM_W-1:0]    acc_sum;
    logic signed [mbsf_pkg::SUM_W-1:0]    t1_sum;
    logic signed [mbsf_pkg::SUM_W-1:0]    n1_sum;
    logic signed [mbsf_pkg::SUM_W-1:0]    n2_sum;

    logic                                 mul0_done, mul1_done, mul2_done;
    logic signed [mbsf_pkg::PROD_W-1:0]   prod0, prod1, prod2;
    logic                                 mul12_start;
    logic signed [mbsf_pkg::COEF_W-1:0]   mul1_coef, mul2_coef;
    logic signed [mbsf_pkg::SAMPLE_W-1:0] mul12_mplier;

    // request classification and feedback phase select
    always_comb begin
        ch_idx       = mbsf_pkg::CH_IDX_W'(ch_reg);
        in_range     = (int'(item.channel) < mbsf_pkg::MAX_CHANNELS);
        run_filter   = cfg.filter_active && in_range;
        fb_phase     = (state_reg == S_RND);
        mul12_start  = (start && run_filter) || fb_phase;
        mul1_coef    = fb_phase ? cfg.coef_a1 : cfg.coef_b1;
        mul2_coef    = fb_phase ? cfg.coef_a2 : cfg.coef_b2;
        mul12_mplier = fb_phase ? y_next : item.sample_in;
    end

    // wide sums for the sum, round and update states, each from registers
    always_comb begin
        acc_sum = mbsf_pkg::SUM_W'(prod0) + mbsf_pkg::SUM_W'(z1_reg[ch_idx])
                + mbsf_pkg::ROUND_HALF;
        t1_sum  = mbsf_pkg::SUM_W'(prod1) + mbsf_pkg::SUM_W'(z2_reg[ch_idx]);
        y_next  = mbsf_pkg::sat_sample(acc_reg >>> mbsf_pkg::FRAC_W);
        n1_sum  = t1_reg - mbsf_pkg::SUM_W'(prod1);
        n2_sum  = mbsf_pkg::SUM_W'(bx2_reg) - mbsf_pkg::SUM_W'(prod2);
    end

    mbsf_serial_mul u_mul0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start && run_filter),
        .coef    (cfg.coef_b0),
        .mplier  (item.sample_in),
        .done    (mul0_done),
        .product (prod0)
    );

    mbsf_serial_mul u_mul1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul12_start),
        .coef    (mul1_coef),
        .mplier  (mul12_mplier),
        .done    (mul1_done),
        .product (prod1)
    );

    mbsf_serial_mul u_mul2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul12_start),
        .coef    (mul2_coef),
        .mplier  (mul12_mplier),
        .done    (mul2_done),
        .product (prod2)
    );

    // sequencer, delay state and registered result
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            res_reg   <= '0;
            for (int i = 0; i < mbsf_pkg::MAX_CHANNELS; i++) begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        if (run_filter) begin
                            state_reg <= S_MULX;
                        end else begin
                            res_reg   <= item.sample_in;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_MULX: begin
                    if (mul0_done) begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    state_reg <= S_RND;
                end
                S_RND: begin
                    state_reg <= S_MULY;
                end
                S_MULY: begin
                    if (mul1_done && mul2_done) begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    z1_reg[ch_idx] <= mbsf_pkg::sat_delay(n1_sum);
                    z2_reg[ch_idx] <= mbsf_pkg::sat_delay(n2_sum);
                    res_reg        <= eq_reg ? y_reg : x_reg;
                    state_reg      <= S_DONE;
                end
                S_DONE: begin
                    if (res_ack) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // per-request working registers
    always_ff @(posedge clk) begin
        if (start) begin
            x_reg  <= item.sample_in;
            ch_reg <= item.channel;
            eq_reg <= cfg.eq_in;
        end
        if (state_reg == S_SUM) begin
            acc_reg <= acc_sum;
            t1_reg  <= t1_sum;
            bx2_reg <= prod2;
        end
        if (state_reg == S_RND) begin
            y_reg <= y_next;
        end
    end

    assign stat.busy          = (state_reg != S_IDLE);
    assign stat.res_valid     = (state_reg == S_DONE);
    assign result.sample_out  = res_reg;
    assign result.channel_out = ch_reg;

endmodule

@@ src/multichannel_biquad_shelf_filter.sv @@
// top level of the multichannel biquad shelf filter: registers, handshake, output stage
//
// Transposed direct form II biquad on signed 24-bit samples, with two 48-bit
// delay terms per channel and Q4.23 coefficients written through the register
// port; the user must write them only while the block is idle, which the block
// does not enforce itself. One request is worked at a time. A filtered request
// runs two 24-step bit-serial multiply passes one after the other, the
// feedforward products first and then the feedback products, since those need
// the rounded and saturated output sample. A bypassed request (filter inactive
// or channel without state) skips them. The next request is accepted at the
// edge after the result has moved to the output register, even if it is stalled.
module multichannel_biquad_shelf_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mbsf_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mbsf_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [mbsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mbsf_pkg::cfg_t       cfg_reg;
    mbsf_pkg::core_stat_t core_stat;
    mbsf_pkg::out_item_t  core_result;
    mbsf_pkg::out_item_t  out_data_reg;
    logic                 out_valid_reg;
    logic                 accept;
    logic                 res_ack;

    // handshake
    assign in_stall = core_stat.busy;
    assign accept   = in_valid && !in_stall;
    assign res_ack  = core_stat.res_valid && (!out_valid_reg || !out_stall);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_b0       <= '0;
            cfg_reg.coef_b1       <= '0;
            cfg_reg.coef_b2       <= '0;
            cfg_reg.coef_a1       <= '0;
            cfg_reg.coef_a2       <= '0;
            cfg_reg.eq_in         <= 1'b1;
            cfg_reg.filter_active <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbsf_pkg::REG_COEF_B0:       cfg_reg.coef_b0       <= cfg_data;
                mbsf_pkg::REG_COEF_B1:       cfg_reg.coef_b1       <= cfg_data;
                mbsf_pkg::REG_COEF_B2:       cfg_reg.coef_b2       <= cfg_data;
                mbsf_pkg::REG_COEF_A1:       cfg_reg.coef_a1       <= cfg_data;
                mbsf_pkg::REG_COEF_A2:       cfg_reg.coef_a2       <= cfg_data;
                mbsf_pkg::REG_EQ_IN:         cfg_reg.eq_in         <= cfg_data[0];
                mbsf_pkg::REG_FILTER_ACTIVE: cfg_reg.filter_active <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    mbsf_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .item    (in_data),
        .cfg     (cfg_reg),
        .res_ack (res_ack),
        .stat    (core_stat),
        .result  (core_result)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_data_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/mbsf_checker.sv @@
// port-level checker for the shelf filter and its bind to the top level
`include "multichannel_biquad_shelf_filter_assert.svh"

module mbsf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input mbsf_pkg::out_item_t             out_data,
    input logic                            cfg_we
);

    // a stalled result stays put
    `MBSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled result changed")

    // one request in work at a time
    `MBSF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "no stall after accepted request")

    // a new result only comes out of a request in work
    `MBSF_ASSERT_SAME(a_out_from_work, $rose(out_valid), $past(in_stall),
        "result without request in work")

    // registers change only while nothing is in work
    `MBSF_ASSERT_SAME(a_cfg_idle, cfg_we, !in_stall, "register write during a request")

endmodule

bind multichannel_biquad_shelf_filter mbsf_checker u_mbsf_checker (.*);

@@ dv/tb_top.sv @@
// self-checking testbench for the multichannel biquad shelf filter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // register index past the end of the map, must be ignored
    localparam logic [mbsf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [mbsf_pkg::COEF_W-1:0] COEF_MAX =
        {1'b0, {(mbsf_pkg::COEF_W-1){1'b1}}};
    localparam logic signed [mbsf_pkg::COEF_W-1:0] COEF_MIN =
        {1'b1, {(mbsf_pkg::COEF_W-1){1'b0}}};
    localparam logic signed [mbsf_pkg::COEF_W-1:0] COEF_ONE = 27'sd1 <<< mbsf_pkg::FRAC_W;
    localparam logic signed [mbsf_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
        {1'b0, {(mbsf_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic signed [mbsf_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
        {1'b1, {(mbsf_pkg::SAMPLE_W-1){1'b0}}};

    localparam longint SAMPLE_HI  = (64'sd1 <<< (mbsf_pkg::SAMPLE_W-1)) - 1;
    localparam longint SAMPLE_LO  = -(64'sd1 <<< (mbsf_pkg::SAMPLE_W-1));
    localparam longint DELAY_HI   = (64'sd1 <<< (mbsf_pkg::DELAY_W-1)) - 1;
    localparam longint DELAY_LO   = -(64'sd1 <<< (mbsf_pkg::DELAY_W-1));
    localparam longint ROUND_BIAS = 64'sd1 <<< (mbsf_pkg::FRAC_W-1);

    localparam int CHUNKS_PER_PHASE = 4;
    localparam int ITEMS_PER_CHUNK  = 47;

    logic                                  clk;
    logic                                  rst_n     = 1'b0;
    logic                                  in_valid  = 1'b0;
    logic                                  in_stall;
    mbsf_pkg::in_item_t                    in_data   = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    mbsf_pkg::out_item_t                   out_data;
    logic                                  cfg_we    = 1'b0;
    logic [mbsf_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [mbsf_pkg::CFG_DATA_W-1:0]       cfg_data  = '0;

    // idle and stall odds in percent
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    // shadow copy of the register file, at reset values
    logic signed [mbsf_pkg::COEF_W-1:0] shadow_b0 = '0;
    logic signed [mbsf_pkg::COEF_W-1:0] shadow_b1 = '0;
    logic signed [mbsf_pkg::COEF_W-1:0] shadow_b2 = '0;
    logic signed [mbsf_pkg::COEF_W-1:0] shadow_a1 = '0;
    logic signed [mbsf_pkg::COEF_W-1:0] shadow_a2 = '0;
    logic                               shadow_eq     = 1'b1;
    logic                               shadow_active = 1'b0;

    // per-channel delay terms of the predictor
    logic signed [mbsf_pkg::DELAY_W-1:0] delay_one [mbsf_pkg::MAX_CHANNELS] = '{default: '0};
    logic signed [mbsf_pkg::DELAY_W-1:0] delay_two [mbsf_pkg::MAX_CHANNELS] = '{default: '0};

    mbsf_pkg::out_item_t expected_samples [$];

    int n_requests   = 0;
    int n_filtered   = 0;
    int n_results    = 0;
    int n_cfg_writes = 0;
    int n_mismatch   = 0;

    multichannel_biquad_shelf_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // transposed direct form II step, updates the channel state
    function automatic mbsf_pkg::out_item_t predict_filter(input mbsf_pkg::in_item_t req);
        longint              x;
        longint              y;
        longint              acc;
        longint              n1;
        longint              n2;
        int                  ch;
        mbsf_pkg::out_item_t res;
        x  = longint'($signed(req.sample_in));
        ch = int'(req.channel);
        res.sample_out  = req.sample_in;
        res.channel_out = req.channel;
        if (shadow_active && ch < mbsf_pkg::MAX_CHANNELS)
        begin
            acc = longint'(shadow_b0) * x + longint'(delay_one[ch]);
            y   = clip((acc + ROUND_BIAS) >>> mbsf_pkg::FRAC_W, SAMPLE_LO, SAMPLE_HI);
            n1  = longint'(shadow_b1) * x - longint'(shadow_a1) * y
                  + longint'(delay_two[ch]);
            n2  = longint'(shadow_b2) * x - longint'(shadow_a2) * y;
            delay_one[ch] = mbsf_pkg::DELAY_W'(clip(n1, DELAY_LO, DELAY_HI));
            delay_two[ch] = mbsf_pkg::DELAY_W'(clip(n2, DELAY_LO, DELAY_HI));
            if (shadow_eq)
                res.sample_out = y[mbsf_pkg::SAMPLE_W-1:0];
            n_filtered++;
        end
        return res;
    endfunction

    function automatic mbsf_pkg::in_item_t make_request(
        input logic signed [mbsf_pkg::SAMPLE_W-1:0] sample,
        input logic ch);
        mbsf_pkg::in_item_t req;
        req.sample_in = sample;
        req.channel   = ch;
        return req;
    endfunction

    // mix of extremes, small values and full-range samples
    function automatic mbsf_pkg::in_item_t random_request();
        mbsf_pkg::in_item_t req;
        case ($urandom_range(9))
            0:       req.sample_in = ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2:    req.sample_in = mbsf_pkg::SAMPLE_W'(int'($urandom_range(510)) - 255);
            default: req.sample_in = mbsf_pkg::SAMPLE_W'($urandom());
        endcase
        req.channel = 1'($urandom_range(1));
        return req;
    endfunction

    // stop sending until every pending result has come back
    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_samples.size() != 0);
    endtask

    // one register write, only while the filter is idle
    task automatic write_reg(input logic [mbsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbsf_pkg::CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mbsf_pkg::REG_COEF_B0:       shadow_b0 = value;
            mbsf_pkg::REG_COEF_B1:       shadow_b1 = value;
            mbsf_pkg::REG_COEF_B2:       shadow_b2 = value;
            mbsf_pkg::REG_COEF_A1:       shadow_a1 = value;
            mbsf_pkg::REG_COEF_A2:       shadow_a2 = value;
            mbsf_pkg::REG_EQ_IN:         shadow_eq = value[0];
            mbsf_pkg::REG_FILTER_ACTIVE: shadow_active = value[0];
            default:                     ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic write_coefs(input logic signed [mbsf_pkg::COEF_W-1:0] b0, b1, b2, a1, a2);
        write_reg(mbsf_pkg::REG_COEF_B0, b0);
        write_reg(mbsf_pkg::REG_COEF_B1, b1);
        write_reg(mbsf_pkg::REG_COEF_B2, b2);
        write_reg(mbsf_pkg::REG_COEF_A1, a1);
        write_reg(mbsf_pkg::REG_COEF_A2, a2);
    endtask

    // send one request with random idle cycles ahead of it
    task automatic send_request(input mbsf_pkg::in_item_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_samples.push_back(predict_filter(req));
        n_requests++;
    endtask

    // result check and random receiver stall
    always @(posedge clk)
    begin : result_check
        mbsf_pkg::out_item_t want;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_samples.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: sample %0d ch %0d",
                             out_data.sample_out, out_data.channel_out);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (out_data.sample_out !== want.sample_out ||
                    out_data.channel_out !== want.channel_out)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch at %0t: expected sample %0d ch %0d, ",
                                  "got sample %0d ch %0d"},
                                 $realtime, want.sample_out, want.channel_out,
                                 out_data.sample_out, out_data.channel_out);
                end
            end
        end
    end

    // reset values: bypass, then zero coefficients with filtered output
    task automatic test_reset_defaults();
        send_request(make_request(SAMPLE_MAX, 1'b0));
        send_request(make_request(SAMPLE_MIN, 1'b1));
        send_request(make_request('0, 1'b0));
        send_request(make_request(-24'sd1, 1'b1));
        write_reg(mbsf_pkg::REG_FILTER_ACTIVE, mbsf_pkg::CFG_DATA_W'(1));
        send_request(make_request(SAMPLE_MAX, 1'b0));
    endtask

    // unity gain passes samples, half gain shows round half up
    task automatic test_unity_and_rounding();
        write_reg(mbsf_pkg::REG_COEF_B0, COEF_ONE);
        send_request(make_request(SAMPLE_MAX, 1'b0));
        send_request(make_request(SAMPLE_MIN, 1'b1));
        send_request(make_request(SAMPLE_MIN, 1'b0));
        send_request(make_request(SAMPLE_MAX, 1'b1));
        write_reg(mbsf_pkg::REG_COEF_B0, COEF_ONE >>> 1);
        send_request(make_request(24'sd1, 1'b0));
        send_request(make_request(-24'sd1, 1'b0));
        send_request(make_request(24'sd3, 1'b1));
        send_request(make_request(-24'sd3, 1'b1));
    endtask

    // extreme coefficients drive output and delay terms into saturation
    task automatic test_saturation();
        write_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_request(make_request(SAMPLE_MAX, 1'b0));
        send_request(make_request(SAMPLE_MAX, 1'b0));
        send_request(make_request(SAMPLE_MIN, 1'b0));
        send_request(make_request(SAMPLE_MIN, 1'b1));
    endtask

    // dry output still advances the state
    task automatic test_dry_output();
        write_coefs(COEF_ONE >>> 1, COEF_ONE >>> 2, -(COEF_ONE >>> 3),
                    -(COEF_ONE >>> 1), COEF_ONE >>> 2);
        write_reg(mbsf_pkg::REG_EQ_IN, mbsf_pkg::CFG_DATA_W'(0));
        send_request(make_request(24'sd1000000, 1'b0));
        send_request(make_request(-24'sd500000, 1'b1));
        write_reg(mbsf_pkg::REG_EQ_IN, mbsf_pkg::CFG_DATA_W'(1));
        send_request(make_request(24'sd123456, 1'b0));
    endtask

    // bypass freezes state, out-of-map register write changes nothing
    task automatic test_bypass_freeze();
        write_reg(mbsf_pkg::REG_FILTER_ACTIVE, mbsf_pkg::CFG_DATA_W'(0));
        send_request(make_request(24'sd777, 1'b0));
        send_request(make_request(SAMPLE_MIN, 1'b1));
        write_reg(REG_UNUSED, mbsf_pkg::CFG_DATA_W'($urandom()));
        write_reg(mbsf_pkg::REG_FILTER_ACTIVE, mbsf_pkg::CFG_DATA_W'(1));
        send_request(make_request(-24'sd4242, 1'b0));
    endtask

    // new register setting: stable shelf-like, arbitrary or extreme
    task automatic randomize_filter();
        logic signed [mbsf_pkg::COEF_W-1:0] c [5];
        int a2;
        int lim;
        case ($urandom_range(9))
            0:
                foreach (c[i])
                    case ($urandom_range(2))
                        0:       c[i] = COEF_MAX;
                        1:       c[i] = COEF_MIN;
                        default: c[i] = '0;
                    endcase
            1, 2:
                foreach (c[i])
                    c[i] = mbsf_pkg::COEF_W'($urandom());
            default:
            begin
                // poles kept inside the stability triangle
                a2  = int'($urandom_range(2 * 7549747)) - 7549747;
                lim = ((8388608 + a2) * 19) / 20;
                for (int i = 0; i < 3; i++)
                    c[i] = mbsf_pkg::COEF_W'(int'($urandom_range(1 << 25)) - (1 << 24));
                c[3] = mbsf_pkg::COEF_W'(int'($urandom_range(2 * lim)) - lim);
                c[4] = mbsf_pkg::COEF_W'(a2);
            end
        endcase
        write_coefs(c[0], c[1], c[2], c[3], c[4]);
        write_reg(mbsf_pkg::REG_EQ_IN, mbsf_pkg::CFG_DATA_W'($urandom_range(4) != 0));
        write_reg(mbsf_pkg::REG_FILTER_ACTIVE,
                  mbsf_pkg::CFG_DATA_W'($urandom_range(5) != 0));
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (CHUNKS_PER_PHASE)
        begin
            randomize_filter();
            repeat (ITEMS_PER_CHUNK)
                send_request(random_request());
        end
    endtask

    // random traffic under four idle and stall mixes
    task automatic test_random_traffic();
        run_phase(0, 0);
        run_phase(81, 0);
        run_phase(0, 81);
        run_phase(37, 37);
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_unity_and_rounding();
        test_saturation();
        test_dry_output();
        test_bypass_freeze();
        test_random_traffic();

        wait_idle();
        repeat (80) @(posedge clk);

        $display("covered %0d requests (%0d through the filter), %0d results, %0d register writes",
                 n_requests, n_filtered, n_results, n_cfg_writes);
        $display("directed extremes plus random traffic with sender gaps and receiver stalls");
        if (n_mismatch == 0 && expected_samples.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/mbsf_pkg.sv
src/mbsf_serial_mul.sv
src/mbsf_core.sv
src/multichannel_biquad_shelf_filter.sv
src/mbsf_checker.sv
dv/tb_top.sv
